FILE: hw/rtl/e2c_pkg.sv
`timescale 1ns / 1ps
package e2c_pkg;

	localparam int MAX_SRC_WIDTH    = 512;
	localparam int MAX_SRC_HEIGHT   = 256;
	localparam int CHANNELS         = 4;
	localparam int WEIGHT_FRAC_BITS = 8;

	localparam int CORDIC_STEPS = 15;
	localparam int GAIN_Q14     = 26981;
	localparam int CW           = 24;
	localparam int AW           = 18;

	localparam int UW_MAX = 12;
	localparam int VW_MAX = 11;
	localparam int FW_MAX = 16;

	localparam int QDEPTH = 32;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_RENDER = 2'd1;
	localparam logic [1:0] KIND_DROP   = 2'd2;

	localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;

	localparam logic [2:0] FACE_NX = 3'd0;
	localparam logic [2:0] FACE_NY = 3'd1;
	localparam logic [2:0] FACE_PX = 3'd2;
	localparam logic [2:0] FACE_PY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	typedef struct packed {
		logic        operation;
		logic [8:0]  texel_x;
		logic [7:0]  texel_y;
		logic [31:0] texel_color;
		logic [2:0]  face;
		logic [6:0]  col;
		logic [6:0]  row;
	} in_item_t;

	typedef struct packed {
		logic [8:0]  dest_x;
		logic [8:0]  dest_y;
		logic [31:0] color;
	} out_item_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [8:0]           tx;
		logic [7:0]           ty;
		logic [31:0]          tcolor;
		logic signed [9:0]    dz;
		logic signed [AW-1:0] theta;
		logic [8:0]           dest_x;
		logic [8:0]           dest_y;
	} side_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [UW_MAX-1:0] u1;
		logic [UW_MAX-1:0] u2;
		logic [VW_MAX-1:0] v1;
		logic [VW_MAX-1:0] v2;
		logic [FW_MAX-1:0] s;
		logic [FW_MAX-1:0] t;
		logic [8:0]        dest_x;
		logic [8:0]        dest_y;
		logic [31:0]       data;
	} q_entry_t;

	function automatic logic signed [AW-1:0] atan_turn(input int k);
		case (k)
			0:       atan_turn = AW'(8192);
			1:       atan_turn = AW'(4836);
			2:       atan_turn = AW'(2555);
			3:       atan_turn = AW'(1297);
			4:       atan_turn = AW'(651);
			5:       atan_turn = AW'(326);
			6:       atan_turn = AW'(163);
			7:       atan_turn = AW'(81);
			8:       atan_turn = AW'(41);
			9:       atan_turn = AW'(20);
			10:      atan_turn = AW'(10);
			11:      atan_turn = AW'(5);
			12:      atan_turn = AW'(3);
			13:      atan_turn = AW'(1);
			14:      atan_turn = AW'(1);
			default: atan_turn = '0;
		endcase
	endfunction

endpackage

FILE: hw/rtl/equirect_to_cube_cross_resampler_core.sv
`timescale 1ns / 1ps
// Equirectangular to vertical-cross resampler. A load command inside the image
// writes its texel to the single-port image memory in the back end; a render
// reads four source texels from it, one at a time, and the back end takes no new
// command before the last read. Up to 32 commands may be accepted and not yet
// taken by the back end; busy rises when that many are outstanding. The result
// is on result for exactly the cycle in which done is high and cannot be held off
// by the receiver. Loads and bad faces give no result. Configuration writes are
// taken at once (cfg_ready stays high).
module equirect_to_cube_cross_resampler_core #(
	parameter int MAX_SRC_WIDTH    = e2c_pkg::MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT   = e2c_pkg::MAX_SRC_HEIGHT,
	parameter int CHANNELS         = e2c_pkg::CHANNELS,
	parameter int WEIGHT_FRAC_BITS = e2c_pkg::WEIGHT_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  e2c_pkg::in_item_t   item,
	output logic                done,
	output e2c_pkg::out_item_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int NW = $clog2(e2c_pkg::QDEPTH + 1);

	logic [9:0]    src_width_q;
	logic [8:0]    src_height_q;
	logic [NW-1:0] occ_q;
	logic          acc, push, pop, empty;
	e2c_pkg::q_entry_t push_data, head;

	assign cfg_ready = 1'b1;
	assign busy      = (occ_q == NW'(e2c_pkg::QDEPTH));
	assign acc       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 10'd512;
			src_height_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				e2c_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_data[9:0];
				e2c_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + NW'(acc) - NW'(pop);
		end
	end

	e2c_front #(
		.MAX_SRC_WIDTH    (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT   (MAX_SRC_HEIGHT),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.item       (item),
		.src_width  (src_width_q),
		.src_height (src_height_q),
		.push       (push),
		.push_data  (push_data)
	);

	e2c_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	e2c_back #(
		.MAX_SRC_WIDTH    (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT   (MAX_SRC_HEIGHT),
		.CHANNELS         (CHANNELS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

FILE: hw/rtl/e2c_cordic.sv
`timescale 1ns / 1ps
module e2c_cordic #(
	parameter int SBW = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [e2c_pkg::CW-1:0]      in_x,
	input  logic signed [e2c_pkg::CW-1:0]      in_y,
	input  logic [SBW-1:0]                     in_sb,
	output logic                               out_valid,
	output logic signed [e2c_pkg::AW-1:0]      out_ang,
	output logic signed [e2c_pkg::CW-1:0]      out_mag,
	output logic [SBW-1:0]                     out_sb
);

	localparam int STAGES = e2c_pkg::CORDIC_STEPS + 1;
	localparam logic signed [e2c_pkg::AW-1:0] QUARTER = e2c_pkg::AW'(16384);

	logic [STAGES-1:0]                vld_s;
	logic signed [e2c_pkg::CW-1:0]    x_s [STAGES];
	logic signed [e2c_pkg::CW-1:0]    y_s [STAGES];
	logic signed [e2c_pkg::AW-1:0]    z_s [STAGES];
	logic                             zero_s [STAGES];
	logic [SBW-1:0]                   sb_s [STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (in_x == '0) && (in_y == '0);
		sb_s[0]   <= in_sb;
		if (in_x < 0) begin
			if (in_y >= 0) begin
				x_s[0] <= in_y;
				y_s[0] <= -in_x;
				z_s[0] <= QUARTER;
			end else begin
				x_s[0] <= -in_y;
				y_s[0] <= in_x;
				z_s[0] <= -QUARTER;
			end
		end else begin
			x_s[0] <= in_x;
			y_s[0] <= in_y;
			z_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < e2c_pkg::CORDIC_STEPS; k++) begin : g_it
		always_ff @(posedge clk) begin
			zero_s[k+1] <= zero_s[k];
			sb_s[k+1]   <= sb_s[k];
			if (y_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + e2c_pkg::atan_turn(k);
			end else begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - e2c_pkg::atan_turn(k);
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_ang   = zero_s[STAGES-1] ? '0 : z_s[STAGES-1];
	assign out_mag   = zero_s[STAGES-1] ? '0 : x_s[STAGES-1];
	assign out_sb    = sb_s[STAGES-1];

endmodule

FILE: hw/rtl/e2c_front.sv
`timescale 1ns / 1ps
module e2c_front #(
	parameter int MAX_SRC_WIDTH    = e2c_pkg::MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT   = e2c_pkg::MAX_SRC_HEIGHT,
	parameter int WEIGHT_FRAC_BITS = e2c_pkg::WEIGHT_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  e2c_pkg::in_item_t  item,
	input  logic [9:0]         src_width,
	input  logic [8:0]         src_height,
	output logic               push,
	output e2c_pkg::q_entry_t  push_data
);

	localparam int CW  = e2c_pkg::CW;
	localparam int AW  = e2c_pkg::AW;
	localparam int SBW = $bits(e2c_pkg::side_t);
	localparam int WFB = WEIGHT_FRAC_BITS;

	logic [9:0] effw;
	logic [8:0] effh;
	logic [7:0] fs;

	always_comb begin
		effw = (32'(src_width) < MAX_SRC_WIDTH) ? src_width : 10'(MAX_SRC_WIDTH);
		if (effw == '0) begin
			effw = 10'd1;
		end
		effh = (32'(src_height) < MAX_SRC_HEIGHT) ? src_height : 9'(MAX_SRC_HEIGHT);
		if (effh == '0) begin
			effh = 9'd1;
		end
	end
	assign fs = effw[9:2];

	// classify and form the direction vector
	logic              vld_s1;
	e2c_pkg::side_t    side_s1;
	logic signed [9:0] dx_s1, dy_s1;

	logic signed [9:0] sfs, pi, mi, pj, mj, dx_c, dy_c, dz_c;
	logic [9:0]        ox_c, oy_c, fs1, fs2, fs3;
	logic [1:0]        kind_c;

	always_comb begin
		sfs  = $signed({2'b00, fs});
		pi   = $signed({2'b00, item.col, 1'b0}) - sfs;
		mi   = sfs - $signed({2'b00, item.col, 1'b0});
		pj   = $signed({2'b00, item.row, 1'b0}) - sfs;
		mj   = sfs - $signed({2'b00, item.row, 1'b0});
		fs1  = {2'b00, fs};
		fs2  = {1'b0, fs, 1'b0};
		fs3  = fs1 + fs2;
		dx_c = '0;
		dy_c = '0;
		dz_c = '0;
		ox_c = '0;
		oy_c = '0;
		kind_c = e2c_pkg::KIND_RENDER;
		case (item.face)
			e2c_pkg::FACE_NX: begin
				dx_c = -sfs; dy_c = pi; dz_c = pj; ox_c = fs1; oy_c = fs3;
			end
			e2c_pkg::FACE_NY: begin
				dx_c = pi; dy_c = -sfs; dz_c = mj; ox_c = '0; oy_c = fs1;
			end
			e2c_pkg::FACE_PX: begin
				dx_c = sfs; dy_c = pi; dz_c = mj; ox_c = fs1; oy_c = fs1;
			end
			e2c_pkg::FACE_PY: begin
				dx_c = mi; dy_c = sfs; dz_c = mj; ox_c = fs2; oy_c = fs1;
			end
			e2c_pkg::FACE_PZ: begin
				dx_c = pj; dy_c = pi; dz_c = sfs; ox_c = fs1; oy_c = '0;
			end
			e2c_pkg::FACE_NZ: begin
				dx_c = mj; dy_c = pi; dz_c = -sfs; ox_c = fs1; oy_c = fs2;
			end
			default: begin
				kind_c = e2c_pkg::KIND_DROP;
			end
		endcase
		if (item.operation == e2c_pkg::OP_LOAD) begin
			if ((32'(item.texel_x) < MAX_SRC_WIDTH) && (32'(item.texel_y) < MAX_SRC_HEIGHT)) begin
				kind_c = e2c_pkg::KIND_LOAD;
			end else begin
				kind_c = e2c_pkg::KIND_DROP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.kind   <= kind_c;
		side_s1.tx     <= item.texel_x;
		side_s1.ty     <= item.texel_y;
		side_s1.tcolor <= item.texel_color;
		side_s1.dz     <= dz_c;
		side_s1.theta  <= '0;
		side_s1.dest_x <= 9'({3'b000, item.col} + ox_c);
		side_s1.dest_y <= 9'({3'b000, item.row} + oy_c);
		dx_s1          <= dx_c;
		dy_s1          <= dy_c;
	end

	// longitude
	logic                 c1_vld;
	logic signed [AW-1:0] c1_ang;
	logic signed [CW-1:0] c1_mag;
	logic [SBW-1:0]       c1_sb;

	e2c_cordic #(.SBW(SBW)) u_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_x      ({{(CW-18){dx_s1[9]}}, dx_s1, 8'b0}),
		.in_y      ({{(CW-18){dy_s1[9]}}, dy_s1, 8'b0}),
		.in_sb     (side_s1),
		.out_valid (c1_vld),
		.out_ang   (c1_ang),
		.out_mag   (c1_mag),
		.out_sb    (c1_sb)
	);

	// apply gain to z
	e2c_pkg::side_t       side_c1, side_s2;
	logic                 vld_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic signed [25:0]   gprod;

	always_comb begin
		side_c1       = c1_sb;
		side_c1.theta = c1_ang;
		gprod         = 26'(side_c1.dz) * 26'(e2c_pkg::GAIN_Q14);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= c1_vld;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_c1;
		x_s2    <= c1_mag;
		y_s2    <= CW'(gprod >>> 6);
	end

	// latitude
	logic                 c2_vld;
	logic signed [AW-1:0] c2_ang;
	logic signed [CW-1:0] c2_mag;
	logic [SBW-1:0]       c2_sb;

	e2c_cordic #(.SBW(SBW)) u_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_x      (x_s2),
		.in_y      (y_s2),
		.in_sb     (side_s2),
		.out_valid (c2_vld),
		.out_ang   (c2_ang),
		.out_mag   (c2_mag),
		.out_sb    (c2_sb)
	);

	// clamp angles
	e2c_pkg::side_t    side_c2, side_s3, side_s4;
	logic              vld_s3, vld_s4, vld_s5;
	logic [16:0]       a_s3, b_s3;
	logic signed [19:0] ta, tb;

	always_comb begin
		side_c2 = c2_sb;
		ta = 20'(side_c2.theta) + 20'sd32768;
		tb = 20'sd16384 - 20'(c2_ang);
	end

	// scale to source coordinates
	logic [26:0] pu_s4, pv_s4;

	// split into index and weight
	localparam int FW_MAX_L = e2c_pkg::FW_MAX;
	logic [31:0] ipu, ipv, emw, emh, u1c, u2c, v1c, v2c;
	logic [FW_MAX_L-1:0] sc, tc;
	e2c_pkg::q_entry_t ent_c, ent_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= c2_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c2;
		if (ta < 0) begin
			a_s3 <= '0;
		end else if (ta > 20'sd65536) begin
			a_s3 <= 17'd65536;
		end else begin
			a_s3 <= ta[16:0];
		end
		if (tb < 0) begin
			b_s3 <= '0;
		end else if (tb > 20'sd32768) begin
			b_s3 <= 17'd32768;
		end else begin
			b_s3 <= tb[16:0];
		end
		side_s4 <= side_s3;
		pu_s4   <= 27'({fs, 2'b00}) * 27'(a_s3);
		pv_s4   <= 27'({fs, 2'b00}) * 27'(b_s3);
		ent_s5  <= ent_c;
	end

	always_comb begin
		ipu = 32'(pu_s4[26:16]);
		ipv = 32'(pv_s4[26:16]);
		emw = 32'(effw) - 32'd1;
		emh = 32'(effh) - 32'd1;
		if (ipu >= emw) begin
			u1c = emw;
			u2c = emw;
			sc  = '0;
		end else begin
			u1c = ipu;
			u2c = ipu + 32'd1;
			sc  = FW_MAX_L'(pu_s4[16-WFB +: WFB]);
		end
		if (ipv >= emh) begin
			v1c = emh;
			v2c = emh;
			tc  = '0;
		end else begin
			v1c = ipv;
			v2c = ipv + 32'd1;
			tc  = FW_MAX_L'(pv_s4[16-WFB +: WFB]);
		end
		ent_c.kind   = side_s4.kind;
		ent_c.u1     = u1c[e2c_pkg::UW_MAX-1:0];
		ent_c.u2     = u2c[e2c_pkg::UW_MAX-1:0];
		ent_c.v1     = v1c[e2c_pkg::VW_MAX-1:0];
		ent_c.v2     = v2c[e2c_pkg::VW_MAX-1:0];
		ent_c.s      = sc;
		ent_c.t      = tc;
		ent_c.dest_x = side_s4.dest_x;
		ent_c.dest_y = side_s4.dest_y;
		ent_c.data   = side_s4.tcolor;
		if (side_s4.kind == e2c_pkg::KIND_LOAD) begin
			ent_c.u1 = e2c_pkg::UW_MAX'(side_s4.tx);
			ent_c.v1 = e2c_pkg::VW_MAX'(side_s4.ty);
		end
	end

	assign push      = vld_s5;
	assign push_data = ent_s5;

endmodule

FILE: hw/rtl/e2c_queue.sv
`timescale 1ns / 1ps
module e2c_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  e2c_pkg::q_entry_t  push_data,
	input  logic               pop,
	output e2c_pkg::q_entry_t  head,
	output logic               empty
);

	localparam int PW = $clog2(e2c_pkg::QDEPTH);
	localparam int NW = $clog2(e2c_pkg::QDEPTH + 1);

	e2c_pkg::q_entry_t ent_q [e2c_pkg::QDEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [NW-1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	assign head  = ent_q[rd_q];
	assign empty = (cnt_q == '0);

endmodule

FILE: hw/rtl/e2c_back.sv
`timescale 1ns / 1ps
module e2c_back #(
	parameter int MAX_SRC_WIDTH    = e2c_pkg::MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT   = e2c_pkg::MAX_SRC_HEIGHT,
	parameter int CHANNELS         = e2c_pkg::CHANNELS,
	parameter int WEIGHT_FRAC_BITS = e2c_pkg::WEIGHT_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  e2c_pkg::q_entry_t   head,
	input  logic                empty,
	output logic                pop,
	output logic                done,
	output e2c_pkg::out_item_t  result
);

	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WFB   = WEIGHT_FRAC_BITS;
	localparam int TW    = 8 + WFB + 1;
	localparam int SW    = TW + WFB + 2;
	localparam logic [WFB:0]  WONE = (WFB+1)'(1) << WFB;
	localparam logic [SW-1:0] HALF = SW'(1) << (2*WFB - 1);

	localparam logic [1:0] CRN_A = 2'd0;
	localparam logic [1:0] CRN_B = 2'd1;
	localparam logic [1:0] CRN_C = 2'd2;
	localparam logic [1:0] CRN_D = 2'd3;

	logic [31:0]       img_q [DEPTH];
	logic [31:0]       rdata_q;
	e2c_pkg::q_entry_t ent_q;
	logic              act_q;
	logic [1:0]        ph_q;

	logic                       mem_we, mem_re;
	logic [1:0]                 ridx;
	logic [e2c_pkg::UW_MAX-1:0] su;
	logic [e2c_pkg::VW_MAX-1:0] sv;
	logic [31:0]                addr_full;
	logic [ADW-1:0]             addr;

	always_comb begin
		pop    = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		ridx   = CRN_A;
		su     = head.u1;
		sv     = head.v1;
		if (act_q) begin
			mem_re = 1'b1;
			ridx   = ph_q;
			case (ph_q)
				CRN_B: begin
					su = ent_q.u2; sv = ent_q.v1;
				end
				CRN_C: begin
					su = ent_q.u1; sv = ent_q.v2;
				end
				default: begin
					su = ent_q.u2; sv = ent_q.v2;
				end
			endcase
		end else if (!empty) begin
			pop = 1'b1;
			case (head.kind)
				e2c_pkg::KIND_LOAD:   mem_we = 1'b1;
				e2c_pkg::KIND_RENDER: mem_re = 1'b1;
				default: ;
			endcase
		end
		addr_full = 32'(sv) * 32'(MAX_SRC_WIDTH) + 32'(su);
		addr      = addr_full[ADW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ph_q  <= CRN_A;
		end else if (act_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == CRN_D) begin
				act_q <= 1'b0;
			end
		end else if (pop && (head.kind == e2c_pkg::KIND_RENDER)) begin
			act_q <= 1'b1;
			ph_q  <= CRN_B;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			img_q[addr] <= head.data;
		end else if (mem_re) begin
			rdata_q <= img_q[addr];
		end
	end

	// capture corners
	logic        rvld_s1;
	logic [1:0]  ridx_s1;
	logic [31:0] pa_q, pb_q, pc_q;
	logic        bl_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= ridx;
		if (rvld_s1) begin
			case (ridx_s1)
				CRN_A:   pa_q <= rdata_q;
				CRN_B:   pb_q <= rdata_q;
				CRN_C:   pc_q <= rdata_q;
				default: ;
			endcase
		end
	end

	assign bl_go = rvld_s1 && (ridx_s1 == CRN_D);

	// blend
	logic         vld_s2, vld_s3;
	logic [WFB:0] t_s2;
	logic [8:0]   dx_s2, dy_s2;
	logic [WFB:0] sw_c, ws_c;
	wire  [31:0]  color_c;
	e2c_pkg::out_item_t res_s3;

	assign sw_c = {1'b0, ent_q.s[WFB-1:0]};
	assign ws_c = WONE - sw_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= bl_go;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (bl_go) begin
			t_s2  <= {1'b0, ent_q.t[WFB-1:0]};
			dx_s2 <= ent_q.dest_x;
			dy_s2 <= ent_q.dest_y;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_ch
		if (c < CHANNELS) begin : g_on
			logic [TW-1:0] top_s2, bot_s2;
			logic [SW-1:0] sum;
			logic [WFB:0]  wt;

			always_ff @(posedge clk) begin
				if (bl_go) begin
					top_s2 <= TW'(pa_q[8*c +: 8]) * TW'(ws_c)
						+ TW'(pb_q[8*c +: 8]) * TW'(sw_c);
					bot_s2 <= TW'(pc_q[8*c +: 8]) * TW'(ws_c)
						+ TW'(rdata_q[8*c +: 8]) * TW'(sw_c);
				end
			end

			assign wt  = WONE - t_s2;
			assign sum = (SW'(top_s2) * SW'(wt) + SW'(bot_s2) * SW'(t_s2) + HALF) >> (2*WFB);
			assign color_c[8*c +: 8] = (sum > SW'(255)) ? 8'hFF : sum[7:0];
		end else begin : g_off
			assign color_c[8*c +: 8] = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			res_s3.dest_x <= dx_s2;
			res_s3.dest_y <= dy_s2;
			res_s3.color  <= color_c;
		end
	end

	assign done   = vld_s3;
	assign result = res_s3;

endmodule

FILE: hw/rtl/e2c_checker.sv
`timescale 1ns / 1ps
module e2c_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!$past(done) && !$past(done, 2) && !$past(done, 3)))
		else $error("results closer than four cycles");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (!busy && !done))
		else $error("activity right after reset");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(arst_n) || !$past(arst_n, 2)) |-> !done)
		else $error("result without a command");

endmodule

bind equirect_to_cube_cross_resampler_core e2c_props u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);

FILE: dv/e2c_checker.sv
`timescale 1ns / 1ps
module e2c_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  e2c_pkg::in_item_t   item,
	input  logic                done,
	input  e2c_pkg::out_item_t  result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  checked
);
	import e2c_pkg::*;

	localparam int TURN_STEP [CORDIC_STEPS] =
		'{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

	logic [31:0] texels [0:MAX_SRC_WIDTH*MAX_SRC_HEIGHT-1];
	logic [9:0] width_reg;
	logic [8:0] height_reg;
	out_item_t pixels_due [$];

	assign pending = pixels_due.size();

	function automatic void vector_angle(input longint xi, input longint yi,
			output longint ang, output longint mag);
		longint x, y, z, sx, sy, t;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			ang = 0;
			mag = 0;
			return;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 16384;
			end else begin
				x = -y;
				y = t;
				z = -16384;
			end
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			sx = y >>> k;
			sy = x >>> k;
			if (y >= 0) begin
				x += sx;
				y -= sy;
				z += TURN_STEP[k];
			end else begin
				x -= sx;
				y += sy;
				z -= TURN_STEP[k];
			end
		end
		ang = z;
		mag = x;
	endfunction

	function automatic void texel_span(input longint q, input longint lim,
			output longint p1, output longint p2, output longint frac);
		longint w, ip;
		w = q >>> (16 - WEIGHT_FRAC_BITS);
		ip = w >>> WEIGHT_FRAC_BITS;
		if (ip >= lim - 1) begin
			p1 = lim - 1;
			p2 = lim - 1;
			frac = 0;
		end else begin
			p1 = ip;
			p2 = ip + 1;
			frac = w & ((1 << WEIGHT_FRAC_BITS) - 1);
		end
	endfunction

	function automatic out_item_t render_pixel(input in_item_t it);
		out_item_t o;
		longint ew, eh, fs, i, j, dx, dy, dz, ox, oy, theta, mag, phi, mag2, a, b;
		longint u1, u2, v1, v2, s, t, wt, top, bot, v;
		logic [31:0] pa, pb, pc, pd;
		ew = width_reg < MAX_SRC_WIDTH ? width_reg : MAX_SRC_WIDTH;
		if (ew < 1) ew = 1;
		eh = height_reg < MAX_SRC_HEIGHT ? height_reg : MAX_SRC_HEIGHT;
		if (eh < 1) eh = 1;
		fs = ew / 4;
		i = it.col;
		j = it.row;
		case (it.face)
			FACE_NX: begin
				dx = -fs; dy = 2*i - fs; dz = 2*j - fs; ox = fs; oy = 3*fs;
			end
			FACE_NY: begin
				dx = 2*i - fs; dy = -fs; dz = fs - 2*j; ox = 0; oy = fs;
			end
			FACE_PX: begin
				dx = fs; dy = 2*i - fs; dz = fs - 2*j; ox = fs; oy = fs;
			end
			FACE_PY: begin
				dx = fs - 2*i; dy = fs; dz = fs - 2*j; ox = 2*fs; oy = fs;
			end
			FACE_PZ: begin
				dx = 2*j - fs; dy = 2*i - fs; dz = fs; ox = fs; oy = 0;
			end
			default: begin
				dx = fs - 2*j; dy = 2*i - fs; dz = -fs; ox = fs; oy = 2*fs;
			end
		endcase
		vector_angle(dx * 256, dy * 256, theta, mag);
		vector_angle(mag, (dz * GAIN_Q14) >>> 6, phi, mag2);
		a = theta + 32768;
		if (a < 0) a = 0;
		if (a > 65536) a = 65536;
		b = 16384 - phi;
		if (b < 0) b = 0;
		if (b > 32768) b = 32768;
		texel_span(4 * fs * a, ew, u1, u2, s);
		texel_span(4 * fs * b, eh, v1, v2, t);
		pa = texels[v1 * MAX_SRC_WIDTH + u1];
		pb = texels[v1 * MAX_SRC_WIDTH + u2];
		pc = texels[v2 * MAX_SRC_WIDTH + u1];
		pd = texels[v2 * MAX_SRC_WIDTH + u2];
		wt = 1 << WEIGHT_FRAC_BITS;
		o.color = '0;
		for (int c = 0; c < CHANNELS && c < 4; c++) begin
			top = pa[8*c +: 8] * (wt - s) + pb[8*c +: 8] * s;
			bot = pc[8*c +: 8] * (wt - s) + pd[8*c +: 8] * s;
			v = (top * (wt - t) + bot * t + ((wt * wt) >> 1)) >> (2 * WEIGHT_FRAC_BITS);
			if (v > 255) v = 255;
			o.color[8*c +: 8] = v[7:0];
		end
		o.dest_x = 9'(i + ox);
		o.dest_y = 9'(j + oy);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_px;
		if (!arst_n) begin
			width_reg <= 10'd512;
			height_reg <= 9'd256;
			errors = 0;
			checked = 0;
			pixels_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SRC_WIDTH)
					width_reg <= cfg_data[9:0];
				else if (cfg_index == CFG_SRC_HEIGHT)
					height_reg <= cfg_data[8:0];
			end
			if (done) begin
				if (pixels_due.size() == 0) begin
					$error("unexpected result beat x=%0d y=%0d color=%h",
						result.dest_x, result.dest_y, result.color);
					errors++;
				end else begin
					exp_px = pixels_due.pop_front();
					checked++;
					if (result.dest_x !== exp_px.dest_x) begin
						$error("dest_x expected %0d actual %0d", exp_px.dest_x, result.dest_x);
						errors++;
					end
					if (result.dest_y !== exp_px.dest_y) begin
						$error("dest_y expected %0d actual %0d", exp_px.dest_y, result.dest_y);
						errors++;
					end
					if (result.color !== exp_px.color) begin
						$error("color expected %h actual %h", exp_px.color, result.color);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (item.operation == OP_LOAD)
					texels[item.texel_y * MAX_SRC_WIDTH + item.texel_x] = item.texel_color;
				else if (item.face <= FACE_NZ)
					pixels_due.push_back(render_pixel(item));
			end
		end
	end
endmodule

FILE: dv/tb_equirect_to_cube_cross_resampler_core.sv
`timescale 1ns / 1ps
module tb_equirect_to_cube_cross_resampler_core;
	import e2c_pkg::*;

	localparam int PRE_W = 16;
	localparam int PRE_H = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	int errors, pending, checked;
	int commands, settings, face_size;
	bit quiet;

	equirect_to_cube_cross_resampler_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	e2c_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
		.pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("timeout");
		$display("FAILURE");
		$finish;
	end

	task automatic issue(input in_item_t it, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		commands++;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_gap();
		if (quiet || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	function automatic in_item_t load_cmd(input int x, input int y, input logic [31:0] c);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.operation = OP_LOAD;
		it.texel_x = 9'(x);
		it.texel_y = 8'(y);
		it.texel_color = c;
		return it;
	endfunction

	function automatic in_item_t render_cmd(input logic [2:0] f, input int i, input int j);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.operation = OP_RENDER;
		it.face = f;
		it.col = 7'(i);
		it.row = 7'(j);
		return it;
	endfunction

	function automatic in_item_t random_cmd();
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		if ($urandom_range(0, 9) < 3) begin
			it.operation = OP_LOAD;
		end else begin
			it.operation = OP_RENDER;
			it.face = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			if (face_size > 0 && $urandom_range(0, 4) != 0) begin
				it.col = 7'($urandom_range(0, face_size - 1));
				it.row = 7'($urandom_range(0, face_size - 1));
			end
		end
		return it;
	endfunction

	task automatic run_phase(input int w, input int h, input int n, input bit pause_once);
		int ew;
		drain();
		write_reg(CFG_SRC_WIDTH, {6'($urandom), 10'(w)});
		write_reg(CFG_SRC_HEIGHT, {7'($urandom), 9'(h)});
		settings++;
		ew = w < MAX_SRC_WIDTH ? w : MAX_SRC_WIDTH;
		face_size = (ew < 1 ? 1 : ew) / 4;
		for (int f = 0; f < 8; f++)
			issue(render_cmd(3'(f), 0, 0), pick_gap());
		issue(render_cmd(FACE_PZ, face_size / 2, face_size / 2), pick_gap());
		issue(render_cmd(FACE_NX, 127, 127), pick_gap());
		for (int k = 0; k < n; k++) begin
			if (pause_once && k == n / 2) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			issue(random_cmd(), pick_gap());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		commands = 0;
		settings = 0;
		face_size = 128;
		quiet = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int y = 0; y < PRE_H; y++)
			for (int x = 0; x < PRE_W; x++)
				issue(load_cmd(x, y, $urandom), 0);
		issue(load_cmd(0, 0, 32'h0000_0000), 0);
		issue(load_cmd(511, 255, 32'hFFFF_FFFF), 0);
		issue(load_cmd(1, 0, 32'hFFFF_FFFF), 0);
		quiet = 1'b0;
		run_phase(16, 10, 90, 1'b1);
		run_phase(4, 1, 50, 1'b0);
		run_phase(16, 511, 50, 1'b0);
		run_phase(0, 0, 40, 1'b0);
		run_phase(3, 2, 40, 1'b0);
		run_phase(8, 4, 70, 1'b0);
		run_phase($urandom_range(4, 16), $urandom_range(1, 511), 70, 1'b0);
		quiet = 1'b1;
		run_phase(12, 6, 70, 1'b0);
		drain();
		$display("Run covered %0d commands (image preload, loads, renders on all faces",
			commands);
		$display("and bad faces) under %0d size settings; %0d pixels checked.",
			settings, checked);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
